FILE: design/wme_pkg.sv
// Shared types and constants for the walkable map erosion block.
// Used by the line buffer, the window cell and the top level. No dependencies.
package wme_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  // Register field widths
  localparam int WREG_W = 12;
  localparam int HREG_W = 13;

  // Row counters: ROW_W holds the height itself, EROW_W a row number
  localparam int ROW_W  = 13;
  localparam int EROW_W = 12;
  localparam logic [HREG_W-1:0] MAX_HEIGHT = 13'd4096;
  localparam logic [HREG_W-1:0] H_RESET    = 13'd256;

  // Input beat kinds
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Attribute bit that marks a blocked cell
  localparam int BLOCK_BIT = 0;

  // Window cell: one column of the 3x3 neighbourhood (upper, middle, current row)
  typedef logic [2:0] wcol_t;

  // Flags carried by a beat in the window stage
  typedef struct packed {
    logic pix;       // beat is a map pixel: updates line buffer and window
    logic emit;      // beat releases one result
    logic interior;  // emitted cell lies off the map border
    logic last;      // emitted cell is the final cell of the map
    logic m1;        // middle row exists (row >= 1)
    logic m2;        // upper row exists (row >= 2)
  } s1_t;

endpackage

FILE: design/wme_linebuf.sv
// Two-row line buffer for the erosion window, one entry of two bits per column.
// Registered read, write-first on an address collision. Uses wme_pkg.
module wme_linebuf #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [1:0]                   rd_data,   // [1] upper row, [0] middle row
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [1:0]                   wr_data
);
  import wme_pkg::*;

  logic [1:0] mem [MAX_WIDTH];
  logic [1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a same-edge write to the same column is passed straight on
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/wme_cell.sv
// One column cell of the 3x3 window chain: holds three map bits and hands
// them to the next cell on every pixel beat. Uses wme_pkg.
module wme_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  wme_pkg::wcol_t col_in,
  output wme_pkg::wcol_t col_out
);
  import wme_pkg::*;

  wcol_t col_r;
  wcol_t col_nxt;

  // Shift in the neighbour's column
  always_comb begin
    col_nxt = col_r;
    if (shift_en) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

FILE: design/walkable_map_erosion_3x3.sv
// Streaming 3x3 erosion of a walkability map.
// Input beats arrive on in_* in raster order. in_tuser selects a pixel (0) or
// a flush tick (1); in_tdata carries the attribute byte, bit 0 set = blocked.
// One result per beat that releases a cell leaves on out_*: out_tdata[0] is 1
// when the cell stays walkable, out_tlast marks the final cell of the map.
// The result for cell (r,c) is released by the beat of cell (r+1,c+1); the
// last row plus one cell (the whole map on a one-row map) come out on the
// beats that follow the final pixel (flush ticks or further pixels), one per beat.
// The releasing beat is registered in the window stage and its result in the output
// register; a full output register that is not taken holds it in the window stage.
// Throughput: one beat per clock while the output side takes results (line buffer
// read registered on acceptance, window shift and write back when the window stage advances).
// in_tready only drops when the output register is full and not taken while a
// beat already waits in the window stage; nothing is lost.
// Reset (rst_n low, synchronous) sets width to 256 (MAX_WIDTH if smaller), height to 256
// and empties the pipeline; the line buffer needs no clearing pass. A cfg_we write sets
// map_width (index 0) or map_height (index 1) and restarts the map; other indexes are
// ignored. The user makes writes only while the block is idle; this is not enforced.
module walkable_map_erosion_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,    // [7:0] attr_byte
  input  logic                             in_tuser,    // [0] command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,   // [0] walkable, [7:1] zero
  output logic                             out_tlast,   // last_pixel
  input  logic                             cfg_we,
  input  logic [wme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wme_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wme_pkg::*;

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int XW    = (WW > WREG_W) ? WW : WREG_W;
  localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;

  // Configuration, stored already saturated
  logic [WW-1:0]     w_eff_r, w_eff_nxt, w_cfg;
  logic [HREG_W-1:0] h_eff_r, h_eff_nxt, h_cfg;
  logic [XW-1:0]     w_raw;
  logic [HREG_W-1:0] h_raw;
  logic              cfg_hit;

  // Input and emit positions
  logic [COLW-1:0]   col_r, col_nxt, ecol_r, ecol_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [EROW_W-1:0] erow_r, erow_nxt;

  // Window stage
  logic            s1_valid_r, s1_valid_nxt;
  s1_t             s1_r, s1_nxt;
  logic [COLW-1:0] s1_col_r;
  logic            s1_blk_r;
  logic            s1_adv;

  // Output register
  logic out_valid_r, out_valid_nxt;
  logic out_walk_r, out_last_r;

  // Accept-side decode
  logic in_acc, done, is_pix, emit_now, col_wrap, ecol_wrap, erow_end, e_last, interior_now;

  // Line buffer and window
  logic [1:0] lb_rd, lb_wr;
  logic       up_b, mid_b;
  wcol_t      win0_q, win1_q;
  logic       win_shift, win_nz;

  // ---------------- configuration ----------------
  assign cfg_hit = cfg_we && ((cfg_index == CFG_IDX_WIDTH) || (cfg_index == CFG_IDX_HEIGHT));
  assign w_raw   = XW'(cfg_data[WREG_W-1:0]);
  assign h_raw   = cfg_data[HREG_W-1:0];

  // Zero maps to one, oversize saturates
  always_comb begin
    if (w_raw == '0) begin
      w_cfg = WW'(1);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w_cfg = WW'(MAX_WIDTH);
    end else begin
      w_cfg = WW'(w_raw);
    end
    if (h_raw == '0) begin
      h_cfg = HREG_W'(1);
    end else if (h_raw > MAX_HEIGHT) begin
      h_cfg = MAX_HEIGHT;
    end else begin
      h_cfg = h_raw;
    end
  end

  always_comb begin
    w_eff_nxt = w_eff_r;
    h_eff_nxt = h_eff_r;
    if (cfg_we && (cfg_index == CFG_IDX_WIDTH)) begin
      w_eff_nxt = w_cfg;
    end
    if (cfg_we && (cfg_index == CFG_IDX_HEIGHT)) begin
      h_eff_nxt = h_cfg;
    end
  end

  // ---------------- accept stage ----------------
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign done      = (row_r == h_eff_r);
  assign is_pix    = !done && (in_tuser == CMD_PIXEL);
  assign emit_now  = done ||
                     (is_pix && ((row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0))));
  assign col_wrap  = ((WW'(col_r) + WW'(1)) == w_eff_r);
  assign ecol_wrap = ((WW'(ecol_r) + WW'(1)) == w_eff_r);
  assign erow_end  = ((ROW_W'(erow_r) + ROW_W'(1)) == h_eff_r);
  assign e_last    = erow_end && ecol_wrap;
  assign interior_now = (erow_r != '0) && ((ROW_W'(erow_r) + ROW_W'(1)) < h_eff_r) &&
                        (ecol_r != '0) && ((WW'(ecol_r) + WW'(1)) < w_eff_r);

  // Position counters; a size register write or the final result restarts the map
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ecol_nxt = ecol_r;
    erow_nxt = erow_r;
    if (cfg_hit) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ecol_nxt = '0;
      erow_nxt = '0;
    end else if (in_acc) begin
      if (is_pix) begin
        if (col_wrap) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_r + COLW'(1);
        end
      end
      if (emit_now) begin
        if (e_last) begin
          col_nxt  = '0;
          row_nxt  = '0;
          ecol_nxt = '0;
          erow_nxt = '0;
        end else if (ecol_wrap) begin
          ecol_nxt = '0;
          erow_nxt = erow_r + EROW_W'(1);
        end else begin
          ecol_nxt = ecol_r + COLW'(1);
        end
      end
    end
  end

  // Window stage load
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    s1_nxt.pix      = is_pix;
    s1_nxt.emit     = emit_now;
    s1_nxt.interior = interior_now;
    s1_nxt.last     = e_last;
    s1_nxt.m1       = (row_r >= ROW_W'(1));
    s1_nxt.m2       = (row_r >= ROW_W'(2));
  end

  // ---------------- line buffer ----------------
  wme_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (in_acc && is_pix),
    .rd_addr (col_r),
    .rd_data (lb_rd),
    .wr_en   (s1_adv && s1_r.pix),
    .wr_addr (s1_col_r),
    .wr_data (lb_wr)
  );

  // Rows that do not exist yet read as free
  assign up_b  = s1_r.m2 && lb_rd[1];
  assign mid_b = s1_r.m1 && lb_rd[0];
  assign lb_wr = {mid_b, s1_blk_r};

  // ---------------- window chain ----------------
  assign win_shift = s1_adv && s1_r.pix;

  wme_cell u_cell0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (win_shift),
    .col_in   ({up_b, mid_b, s1_blk_r}),
    .col_out  (win0_q)
  );

  wme_cell u_cell1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (win_shift),
    .col_in   (win0_q),
    .col_out  (win1_q)
  );

  // Window after this beat's shift: new column plus the two held columns
  assign win_nz = up_b | mid_b | s1_blk_r | (|win0_q) | (|win1_q);

  // ---------------- output register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r     <= WW'(W_RST);
      h_eff_r     <= H_RESET;
      col_r       <= '0;
      row_r       <= '0;
      ecol_r      <= '0;
      erow_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      w_eff_r     <= w_eff_nxt;
      h_eff_r     <= h_eff_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ecol_r      <= ecol_nxt;
      erow_r      <= erow_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r     <= s1_nxt;
      s1_col_r <= col_r;
      s1_blk_r <= in_tdata[BLOCK_BIT];
    end
    if (s1_adv && s1_r.emit) begin
      out_walk_r <= s1_r.interior && !win_nz;
      out_last_r <= s1_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_walk_r};
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------
  // The final result of a map restarts every position counter
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit_now && e_last && !cfg_hit) |=>
      (col_r == '0 && row_r == '0 && ecol_r == '0 && erow_r == '0))
    else $error("positions not cleared after final result");

  // A result waiting in the window stage is never dropped by a stall
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.emit && out_valid_r && !out_tready) |=> s1_valid_r)
    else $error("window stage result lost under stall");

  // Tail beats only release border cells
  a_tail_border: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && done) |-> !interior_now)
    else $error("interior cell released after final pixel");

  // A flush before the map is complete releases nothing
  a_flush_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !done && (in_tuser == CMD_FLUSH)) |-> !emit_now)
    else $error("early flush released a result");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for walkable_map_erosion_3x3: raster maps, flush ticks and register writes,
// with every erosion result predicted locally and checked beat by beat on out_*.
// Depends on wme_pkg and the walkable_map_erosion_3x3 RTL only.
module tb;
  import wme_pkg::*;

  localparam int LINE_MAX       = 2048;
  localparam int ROWS_MAX       = 4096;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RANDOM_BEATS   = 750;
  localparam int IDLE_PCT       = 27;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef struct packed {
    logic walkable;
    logic last_pixel;
  } cell_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;         // [7:0] attr_byte
  logic                  in_tuser   = CMD_PIXEL;  // [0] command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;               // [0] walkable, [7:1] zero
  logic                  out_tlast;               // last_pixel
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  walkable_map_erosion_3x3 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Erosion predictor: line stores, 3x3 window and map position
  // ---------------------------------------------------------------------------
  bit                upper_line  [LINE_MAX];
  bit                middle_line [LINE_MAX];
  bit [8:0]          nbr_window;
  int unsigned       col_at, row_at, cells_out;
  logic [WREG_W-1:0] width_reg;
  logic [HREG_W-1:0] height_reg;

  cell_result_t expected_cells [$];
  int fail_count   = 0;
  int results_seen = 0;
  int beats_sent   = 0;
  int writes_done  = 0;
  int maps_done    = 0;

  function automatic int unsigned cells_per_row();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned rows_per_map();
    if (height_reg == 0) return 1;
    if (height_reg > ROWS_MAX) return ROWS_MAX;
    return height_reg;
  endfunction

  function automatic void restart_map();
    nbr_window = '0;
    col_at     = 0;
    row_at     = 0;
    cells_out  = 0;
  endfunction

  function automatic void reset_model();
    width_reg  = 12'd256;
    height_reg = H_RESET;
    restart_map();
  endfunction

  // Writes to either size register restart the map; spare indexes do nothing
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_IDX_WIDTH: begin
        width_reg = value[WREG_W-1:0];
        restart_map();
      end
      CFG_IDX_HEIGHT: begin
        height_reg = value[HREG_W-1:0];
        restart_map();
      end
      default: ;
    endcase
  endfunction

  // Result for the oldest cell not yet released; border cells are always blocked
  function automatic cell_result_t release_cell(input int unsigned w, input int unsigned h);
    int unsigned  r, c;
    bit           interior;
    cell_result_t res;
    r = cells_out / w;
    c = cells_out % w;
    interior = (r >= 1) && (r + 1 < h) && (c >= 1) && (c + 1 < w);
    res.walkable   = interior && (nbr_window == '0);
    res.last_pixel = (cells_out + 1 == w * h);
    cells_out++;
    if (res.last_pixel) begin
      restart_map();
      maps_done++;
    end
    return res;
  endfunction

  // One accepted beat; returns 1 when it releases a result
  function automatic bit predict_beat(input logic cmd, input logic [7:0] attr,
                                      output cell_result_t res);
    int unsigned w, h, cell_idx;
    bit          blk, up, mid;
    w   = cells_per_row();
    h   = rows_per_map();
    res = '0;
    // all cells in: any beat drains one pending result
    if (row_at >= h) begin
      res = release_cell(w, h);
      return 1'b1;
    end
    if (cmd == CMD_FLUSH) return 1'b0;
    blk = attr[BLOCK_BIT];
    up  = (row_at >= 2) ? upper_line[col_at]  : 1'b0;
    mid = (row_at >= 1) ? middle_line[col_at] : 1'b0;
    cell_idx = row_at * w + col_at;
    upper_line[col_at]  = mid;
    middle_line[col_at] = blk;
    nbr_window = {nbr_window[5:0], up, mid, blk};
    col_at++;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
    end
    if (cell_idx >= w + 1) begin
      res = release_cell(w, h);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches and a requested hold-off
  // ---------------------------------------------------------------------------
  bit calm         = 1'b0;
  int hold_request = 0;
  int hold_left    = 0;

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker: each accepted beat against the oldest expectation
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_cells.size() == 0) begin
        $error("unexpected result beat: walkable=%0b last_pixel=%0b", out_tdata[0], out_tlast);
        fail_count++;
      end else begin
        want = expected_cells.pop_front();
        if (out_tdata[0] !== want.walkable) begin
          $error("walkable: expected %0b, got %0b", want.walkable, out_tdata[0]);
          fail_count++;
        end
        if (out_tlast !== want.last_pixel) begin
          $error("last_pixel: expected %0b, got %0b", want.last_pixel, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_cells.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic cmd, input logic [7:0] attr);
    cell_result_t res;
    // random idle cycles ahead of the beat
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= attr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_beat(cmd, attr, res)) expected_cells = {expected_cells, res};
    beats_sent++;
  endtask

  // Sender pauses until every expected result is out and the pipe has emptied
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    apply_register(idx, value);
    cfg_we <= 1'b0;
    writes_done++;
    @(posedge clk);
  endtask

  task automatic set_map(input int w, input int h);
    wait_idle();
    write_register(CFG_IDX_WIDTH, CFG_DATA_W'(w));
    write_register(CFG_IDX_HEIGHT, CFG_DATA_W'(h));
  endtask

  // Well-formed stream beat: mostly pixels while the map fills, flush noise,
  // a mix of flushes and spare pixels while the tail drains
  task automatic stream_beat(input int blocked_pct);
    logic [7:0] attr;
    bit         draining;
    attr = 8'($urandom_range(255));
    attr[BLOCK_BIT] = ($urandom_range(99) < blocked_pct);
    draining = (row_at >= rows_per_map());
    if ($urandom_range(99) < (draining ? 50 : 8)) send_beat(CMD_FLUSH, attr);
    else send_beat(CMD_PIXEL, attr);
  endtask

  task automatic run_map(input int blocked_pct);
    int start_maps;
    start_maps = maps_done;
    while (maps_done == start_maps) stream_beat(blocked_pct);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // 3x3 maps: one fully free (centre survives), one with two blocked corners
  task automatic test_directed();
    logic [7:0] open_map   [9] = '{8'hFE, 8'h00, 8'hAA, 8'h54, 8'h80,
                                   8'h02, 8'h7E, 8'hFC, 8'h00};
    logic [7:0] corner_map [9] = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 8'h00, 8'h00, 8'hFF};
    set_map(3, 3);
    for (int i = 0; i < 9; i++) begin
      send_beat(CMD_PIXEL, open_map[i]);
      // flush before the map is complete releases nothing
      if (i == 2) send_beat(CMD_FLUSH, 8'hFF);
    end
    // tail: flushes and spare pixels, whose bytes are ignored
    send_beat(CMD_FLUSH, 8'h00);
    send_beat(CMD_PIXEL, 8'hFF);
    send_beat(CMD_FLUSH, 8'h5A);
    send_beat(CMD_PIXEL, 8'h01);
    // next map starts without a register write
    for (int i = 0; i < 9; i++) send_beat(CMD_PIXEL, corner_map[i]);
    repeat (4) send_beat(CMD_FLUSH, 8'h00);
  endtask

  task automatic test_register_extremes();
    // zero sizes act as a single cell
    set_map(0, 0);
    send_beat(CMD_PIXEL, 8'h00);
    send_beat(CMD_FLUSH, 8'hFF);
    send_beat(CMD_PIXEL, 8'hFE);
    send_beat(CMD_PIXEL, 8'h01);
    // width register keeps only its low 12 bits
    set_map(13'h1003, 2);
    run_map(10);
    set_map(2, 5);
    run_map(0);
    // spare indexes are ignored and leave the map in progress alone
    set_map(4, 4);
    repeat (3) send_beat(CMD_PIXEL, 8'h00);
    wait_idle();
    write_register(CFG_IDX_SPARE_A, CFG_DATA_W'($urandom));
    write_register(CFG_IDX_SPARE_B, 13'h1FFF);
    run_map(0);
    // a write part-way through a map drops the cells already sent
    set_map(5, 5);
    repeat (12) send_beat(CMD_PIXEL, 8'h00);
    wait_idle();
    write_register(CFG_IDX_WIDTH, 13'd5);
    run_map(0);
    // widest rows: width saturates, map abandoned within the first row
    set_map(13'h0FFF, 3);
    repeat (40) stream_beat(3);
    // tallest map: height saturates, single column, first rows only
    set_map(1, 13'h1FFF);
    repeat (60) stream_beat(20);
  endtask

  // Both sides at full rate
  task automatic test_full_rate();
    calm = 1'b1;
    set_map(7, 6);
    repeat (3) run_map(3);
    set_map(16, 5);
    run_map(0);
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering beats
    set_map(8, 40);
    hold_request = 300;
    run_map(5);
    // sender stops mid-map until everything expected has come out
    set_map(6, 6);
    repeat (20) stream_beat(10);
    wait_idle();
    run_map(10);
  endtask

  task automatic test_random_maps();
    int first_beat, w, h, pct;
    int pct_menu [5] = '{0, 3, 15, 50, 100};
    first_beat = beats_sent;
    while (beats_sent - first_beat < RANDOM_BEATS) begin
      w   = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
      h   = $urandom_range(12, 1);
      pct = pct_menu[$urandom_range(4)];
      set_map(w, h);
      if ($urandom_range(9) == 0) begin
        // broken map: part of the cells, then restarted by the next write
        repeat ($urandom_range(w * h)) stream_beat(pct);
      end else begin
        repeat ($urandom_range(3, 1)) run_map(pct);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    reset_model();
    test_directed();
    test_register_extremes();
    test_full_rate();
    test_backpressure();
    test_random_maps();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("run: %0d beats in, %0d results out, %0d register writes, %0d maps finished",
             beats_sent, results_seen, writes_done, maps_done);
    $display("covered small and random maps, zero and oversize sizes, restarts, flushes and stalls");
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
